@@ rtl/cmg_pkg.sv @@
// ----------------------------------------------------------------------------
// cmg_pkg: shared types, constants and helpers of the month grid core
// request and cell words, queue entry layout, month length and month offsets
// ----------------------------------------------------------------------------
package cmg_pkg;

    localparam int GRID_CELLS_DEF = 42;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int IDX_W   = 6;
    localparam int WS_W    = 3;
    localparam int LEAD_W  = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [WS_W-1:0]    WS_WRAP   = 3'd7;

    // floor(y / 100) as (y * RECIP100) >> SH100, exact for y below 43690
    localparam int PROD100_W = 28;
    localparam int RECIP100  = 5243;
    localparam int SH100     = 19;
    localparam int Q100_W    = 7;

    // floor(s / 7) as (s * RECIP7) >> SH7, exact for s below 43500
    localparam int SUM_W   = 15;
    localparam int PROD7_W = 30;
    localparam int RECIP7  = 18725;
    localparam int SH7     = 17;
    localparam int Q7_W    = 13;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [YEAR_W-1:0]  req_year;
        logic [MONTH_W-1:0] req_month;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]  cell_year;
        logic [MONTH_W-1:0] cell_month;
        logic [DAY_W-1:0]   cell_day;
        logic [IDX_W-1:0]   cell_index;
        logic               last_cell;
    } t_cell;

    // one classified request, as handed from the front to the back
    typedef struct packed {
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  py;
        logic [MONTH_W-1:0] pm;
        logic [YEAR_W-1:0]  ny;
        logic [MONTH_W-1:0] nm;
        logic [DAY_W-1:0]   plen;
        logic [DAY_W-1:0]   len;
        logic [DAY_W-1:0]   nlen;
        logic [LEAD_W-1:0]  lead;
        logic               leap;
    } t_job;

    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        unique case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd2:                   r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/cmg_front.sv @@
// ----------------------------------------------------------------------------
// cmg_front: request classifier
// clamps the request, finds the weekday of the first, leap year and the
// neighbouring months, and hands one job word per request to the queue
// ----------------------------------------------------------------------------
module cmg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cmg_pkg::t_req              i_req,
    input  logic [cmg_pkg::WS_W-1:0]   i_week_start,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output cmg_pkg::t_job              o_job
);

    localparam int YW = cmg_pkg::YEAR_W;
    localparam int MW = cmg_pkg::MONTH_W;

    // stage 1: clamped request
    logic          r_v1;
    logic [YW-1:0] r1_y, r1_yy, r1_ly;
    logic [MW-1:0] r1_m;
    // stage 2: products for the divisions by 100
    logic          r_v2;
    logic [YW-1:0] r2_y, r2_yy, r2_ly;
    logic [MW-1:0] r2_m;
    logic [cmg_pkg::PROD100_W-1:0] r2_pyy, r2_ply;
    // stage 3: weekday sum and leap flag
    logic          r_v3;
    logic [YW-1:0] r3_y;
    logic [MW-1:0] r3_m;
    logic [cmg_pkg::SUM_W-1:0] r3_s;
    logic          r3_leap;
    // stage 4: product for the modulo 7
    logic          r_v4;
    logic [YW-1:0] r4_y;
    logic [MW-1:0] r4_m;
    logic [cmg_pkg::SUM_W-1:0]   r4_s;
    logic [cmg_pkg::PROD7_W-1:0] r4_ps;
    logic          r4_leap;

    logic en1, en2, en3, en4;
    logic [YW-1:0] yc, yy, ly;
    logic [MW-1:0] mc;
    logic [cmg_pkg::Q100_W-1:0] q100y, q100l;
    logic [YW-1:0] r100;
    logic [cmg_pkg::SUM_W-1:0] s;
    logic [cmg_pkg::Q7_W-1:0] q7;
    logic [2:0] fw;
    logic [cmg_pkg::WS_W-1:0] wsm;
    logic [3:0] diff;
    cmg_pkg::t_job job;

    assign en4 = !r_v4 || i_job_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        if (i_req.req_year < cmg_pkg::YEAR_MIN) begin
            yc = cmg_pkg::YEAR_MIN;
        end else if (i_req.req_year > cmg_pkg::YEAR_MAX) begin
            yc = cmg_pkg::YEAR_MAX;
        end else begin
            yc = i_req.req_year;
        end
        if (i_req.req_month < cmg_pkg::MONTH_JAN) begin
            mc = cmg_pkg::MONTH_JAN;
        end else if (i_req.req_month > cmg_pkg::MONTH_DEC) begin
            mc = cmg_pkg::MONTH_DEC;
        end else begin
            mc = i_req.req_month;
        end
        // weekday uses the year before for january and february
        yy = (mc < cmg_pkg::MONTH_MAR) ? yc - YW'(1) : yc;
        // the only february that needs the leap rule after december is next year's
        ly = (mc == cmg_pkg::MONTH_DEC) ? yc + YW'(1) : yc;
    end

    always_comb begin
        q100y = cmg_pkg::Q100_W'(r2_pyy >> cmg_pkg::SH100);
        q100l = cmg_pkg::Q100_W'(r2_ply >> cmg_pkg::SH100);
        s = cmg_pkg::SUM_W'(r2_yy) + cmg_pkg::SUM_W'(r2_yy >> 2)
            - cmg_pkg::SUM_W'(q100y) + cmg_pkg::SUM_W'(q100y >> 2)
            + cmg_pkg::SUM_W'(cmg_pkg::month_offset(r2_m)) + cmg_pkg::SUM_W'(1);
        r100 = r2_ly - YW'(YW'(q100l) * YW'(100));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_y  <= yc;
            r1_m  <= mc;
            r1_yy <= yy;
            r1_ly <= ly;
        end
        if (en2) begin
            r2_y   <= r1_y;
            r2_m   <= r1_m;
            r2_yy  <= r1_yy;
            r2_ly  <= r1_ly;
            r2_pyy <= cmg_pkg::PROD100_W'(r1_yy) * cmg_pkg::PROD100_W'(cmg_pkg::RECIP100);
            r2_ply <= cmg_pkg::PROD100_W'(r1_ly) * cmg_pkg::PROD100_W'(cmg_pkg::RECIP100);
        end
        if (en3) begin
            r3_y    <= r2_y;
            r3_m    <= r2_m;
            r3_s    <= s;
            r3_leap <= (r100 == '0) ? (q100l[1:0] == 2'd0) : (r2_ly[1:0] == 2'd0);
        end
        if (en4) begin
            r4_y    <= r3_y;
            r4_m    <= r3_m;
            r4_s    <= r3_s;
            r4_ps   <= cmg_pkg::PROD7_W'(r3_s) * cmg_pkg::PROD7_W'(cmg_pkg::RECIP7);
            r4_leap <= r3_leap;
        end
    end

    always_comb begin
        q7   = cmg_pkg::Q7_W'(r4_ps >> cmg_pkg::SH7);
        fw   = 3'(r4_s - cmg_pkg::SUM_W'(cmg_pkg::SUM_W'(q7) * cmg_pkg::SUM_W'(7)));
        wsm  = (i_week_start == cmg_pkg::WS_WRAP) ? '0 : i_week_start;
        diff = {1'b0, fw} + 4'd7 - {1'b0, wsm};

        job      = '0;
        job.y    = r4_y;
        job.m    = r4_m;
        job.leap = r4_leap;
        job.lead = (diff >= 4'd7) ? 3'(diff - 4'd7) : 3'(diff);
        if (r4_m == cmg_pkg::MONTH_JAN) begin
            job.pm = cmg_pkg::MONTH_DEC;
            job.py = r4_y - YW'(1);
        end else begin
            job.pm = r4_m - MW'(1);
            job.py = r4_y;
        end
        if (r4_m == cmg_pkg::MONTH_DEC) begin
            job.nm = cmg_pkg::MONTH_JAN;
            job.ny = r4_y + YW'(1);
        end else begin
            job.nm = r4_m + MW'(1);
            job.ny = r4_y;
        end
        job.plen = cmg_pkg::month_len(job.pm, r4_leap);
        job.len  = cmg_pkg::month_len(r4_m, r4_leap);
        job.nlen = cmg_pkg::month_len(job.nm, r4_leap);
    end

    assign o_job_valid = r_v4;
    assign o_job       = job;

endmodule

@@ rtl/cmg_queue.sv @@
// ----------------------------------------------------------------------------
// cmg_queue: job queue between front and back
// small register fifo, lets the front run ahead while the back emits cells
// ----------------------------------------------------------------------------
module cmg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  cmg_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output cmg_pkg::t_job o_job
);

    cmg_pkg::t_job                 r_mem [cmg_pkg::QUEUE_DEPTH];
    logic [cmg_pkg::QPTR_W-1:0]    r_wp, r_rp;
    logic [cmg_pkg::QCNT_W-1:0]    r_cnt;
    logic                          wr, rd;

    assign o_ready = (r_cnt != cmg_pkg::QCNT_W'(cmg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            // depth is a power of two, pointers wrap on their own
            if (wr) r_wp <= r_wp + cmg_pkg::QPTR_W'(1);
            if (rd) r_rp <= r_rp + cmg_pkg::QPTR_W'(1);
            if (wr && !rd) begin
                r_cnt <= r_cnt + cmg_pkg::QCNT_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - cmg_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
    end

endmodule

@@ rtl/cmg_back.sv @@
// ----------------------------------------------------------------------------
// cmg_back: cell sequencer
// walks a job over the grid, a cell per cycle unless stalled, into a register
// ----------------------------------------------------------------------------
module cmg_back #(
    parameter int GRID_CELLS = cmg_pkg::GRID_CELLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  cmg_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output cmg_pkg::t_cell o_cell
);

    localparam int YW = cmg_pkg::YEAR_W;
    localparam int MW = cmg_pkg::MONTH_W;
    localparam int DW = cmg_pkg::DAY_W;
    localparam int IW = cmg_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(GRID_CELLS - 1);

    localparam logic [1:0] PH_PREV = 2'd0;
    localparam logic [1:0] PH_VIEW = 2'd1;
    localparam logic [1:0] PH_FILL = 2'd2;

    logic          r_busy, n_busy;
    logic [1:0]    r_phase, n_phase;
    logic [IW-1:0] r_k, n_k;
    logic [YW-1:0] r_y, n_y;
    logic [MW-1:0] r_m, n_m;
    logic [DW-1:0] r_d, n_d;
    logic [DW-1:0] r_len, n_len;
    cmg_pkg::t_job r_job, n_job;
    cmg_pkg::t_cell r_out;
    logic          r_out_valid;

    logic adv, last_now, load;
    logic [MW-1:0] fm;
    logic [YW-1:0] fy;

    assign adv      = !r_out_valid || i_ready;
    assign last_now = r_busy && (r_k == LAST_IDX);
    assign load     = i_job_valid && (!r_busy || (adv && last_now));
    assign o_job_pop = load;

    always_comb begin
        fm = (r_m == cmg_pkg::MONTH_DEC) ? cmg_pkg::MONTH_JAN : r_m + MW'(1);
        fy = (r_m == cmg_pkg::MONTH_DEC) ? r_y + YW'(1) : r_y;

        n_busy  = r_busy;
        n_phase = r_phase;
        n_k     = r_k;
        n_y     = r_y;
        n_m     = r_m;
        n_d     = r_d;
        n_len   = r_len;
        n_job   = r_job;

        if (load) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_k    = '0;
            if (i_job.lead != '0) begin
                n_phase = PH_PREV;
                n_y     = i_job.py;
                n_m     = i_job.pm;
                n_d     = i_job.plen - DW'(i_job.lead) + DW'(1);
                n_len   = i_job.plen;
            end else begin
                n_phase = PH_VIEW;
                n_y     = i_job.y;
                n_m     = i_job.m;
                n_d     = DW'(1);
                n_len   = i_job.len;
            end
        end else if (r_busy && adv) begin
            if (last_now) begin
                n_busy = 1'b0;
            end else begin
                n_k = r_k + IW'(1);
                if (r_d == r_len) begin
                    n_d = DW'(1);
                    unique case (r_phase)
                        PH_PREV: begin
                            n_phase = PH_VIEW;
                            n_y     = r_job.y;
                            n_m     = r_job.m;
                            n_len   = r_job.len;
                        end
                        PH_VIEW: begin
                            n_phase = PH_FILL;
                            n_y     = r_job.ny;
                            n_m     = r_job.nm;
                            n_len   = r_job.nlen;
                        end
                        default: begin
                            // long grids roll on past the next month
                            n_phase = PH_FILL;
                            n_y     = fy;
                            n_m     = fm;
                            n_len   = cmg_pkg::month_len(fm, r_job.leap);
                        end
                    endcase
                end else begin
                    n_d = r_d + DW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_PREV;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_k     <= n_k;
            if (adv) r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y   <= n_y;
        r_m   <= n_m;
        r_d   <= n_d;
        r_len <= n_len;
        r_job <= n_job;
        if (adv && r_busy) begin
            r_out.cell_year  <= r_y;
            r_out.cell_month <= r_m;
            r_out.cell_day   <= r_d;
            r_out.cell_index <= r_k;
            r_out.last_cell  <= last_now;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cell  = r_out;

endmodule

@@ rtl/calendar_month_grid_core.sv @@
// ----------------------------------------------------------------------------
// calendar_month_grid_core: month calendar grid generator
// path: front stages, queue, back sequencer, output register, in that order
// throughput: one cell per cycle unless the output stalls, GRID_CELLS cells
//   per request, set by the back sequencer that emits one cell word per cycle
// the front takes new requests while the back works, up to a 2-job queue
// reset: synchronous active low, clears pipeline, queue, output, week_start
// ----------------------------------------------------------------------------
module calendar_month_grid_core #(
    parameter int GRID_CELLS = cmg_pkg::GRID_CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  cmg_pkg::t_req            i_req,
    output logic                     o_valid,
    input  logic                     i_ready,
    output cmg_pkg::t_cell           o_cell,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [cmg_pkg::WS_W-1:0] i_cfg_data
);

    logic [cmg_pkg::WS_W-1:0] r_week_start;
    logic          f_valid, q_ready, q_valid, q_pop;
    cmg_pkg::t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_week_start <= '0;
        end else if (i_cfg_valid) begin
            r_week_start <= i_cfg_data;
        end
    end

    cmg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req        (i_req),
        .i_week_start (r_week_start),
        .o_job_valid  (f_valid),
        .i_job_ready  (q_ready),
        .o_job        (f_job)
    );

    cmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cmg_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cell      (o_cell)
    );

    // cells of one grid come without gaps and in index order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_cell.last_cell) |=>
            (o_valid && o_cell.cell_index ==
                cmg_pkg::IDX_W'($past(o_cell.cell_index) + 1)))
        else $error("cell index did not step");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cell.last_cell ==
            (o_cell.cell_index == cmg_pkg::IDX_W'(GRID_CELLS - 1))))
        else $error("last cell flag wrong");

    a_new_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_cell.last_cell) |=>
            (!o_valid || o_cell.cell_index == '0))
        else $error("grid did not restart at index zero");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cell.cell_day != '0))
        else $error("day zero emitted");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_top: testbench of calendar_month_grid_core
// year/month request words go in with random gaps, cell words come back under
// random stalls; every cell is checked field by field against a month grid
// laid out here for the week start in force when the request was taken
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CELLS         = cmg_pkg::GRID_CELLS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 58;
    localparam int YW            = cmg_pkg::YEAR_W;
    localparam int MW            = cmg_pkg::MONTH_W;

    class grid_tracker;
        localparam int GRID       = cmg_pkg::GRID_CELLS_DEF;
        localparam int MAX_PRINTS = 100;

        cmg_pkg::t_cell           expected_cells[$];
        int unsigned              errors;
        logic [cmg_pkg::WS_W-1:0] week_start;
        int unsigned              month_code[12];

        function new();
            errors     = 0;
            week_start = '0;
            month_code = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        function int unsigned days_in(int unsigned y, int unsigned m);
            if (m == 2) return leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        function void push_cell(int unsigned k, int unsigned y, int unsigned m,
                                int unsigned d);
            cmg_pkg::t_cell c;
            c.cell_year  = y[cmg_pkg::YEAR_W-1:0];
            c.cell_month = m[cmg_pkg::MONTH_W-1:0];
            c.cell_day   = d[cmg_pkg::DAY_W-1:0];
            c.cell_index = k[cmg_pkg::IDX_W-1:0];
            c.last_cell  = (k + 1 == GRID);
            expected_cells.push_back(c);
        endfunction

        // whole grid for one request word
        function void lay_out_month(cmg_pkg::t_req r);
            int unsigned y, m, py, pm, ny, nm, plen, len, yy, wd, lead, k, d;
            y = r.req_year;
            m = r.req_month;
            if (y < 1) y = 1;
            if (y > 9999) y = 9999;
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            py = y;
            pm = m - 1;
            if (pm < 1) begin
                pm = 12;
                py = y - 1;
            end
            ny = y;
            nm = m + 1;
            if (nm > 12) begin
                nm = 1;
                ny = y + 1;
            end
            plen = days_in(py, pm);
            len  = days_in(y, m);
            // january and february count against the year before
            yy   = (m < 3) ? y - 1 : y;
            wd   = (yy + yy / 4 - yy / 100 + yy / 400 + month_code[m - 1] + 1) % 7;
            lead = (wd + 7 - (week_start % 7)) % 7;
            k = 0;
            for (d = 0; d < lead && k < GRID; d++, k++)
                push_cell(k, py, pm, plen - lead + d + 1);
            for (d = 1; d <= len && k < GRID; d++, k++)
                push_cell(k, y, m, d);
            d = 1;
            while (k < GRID) begin
                if (d > days_in(ny, nm)) begin
                    d = 1;
                    nm++;
                    if (nm > 12) begin
                        nm = 1;
                        ny++;
                    end
                end
                push_cell(k, ny, nm, d);
                d++;
                k++;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) $display("%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_cell(cmg_pkg::t_cell got);
            cmg_pkg::t_cell want;
            if (expected_cells.size() == 0) begin
                report($sformatf("cell word with nothing pending: %0d-%0d-%0d index %0d",
                                 got.cell_year, got.cell_month, got.cell_day,
                                 got.cell_index));
                return;
            end
            want = expected_cells.pop_front();
            if (got.cell_year !== want.cell_year)
                report($sformatf("cell %0d year %0d, want %0d",
                                 want.cell_index, got.cell_year, want.cell_year));
            if (got.cell_month !== want.cell_month)
                report($sformatf("cell %0d month %0d, want %0d",
                                 want.cell_index, got.cell_month, want.cell_month));
            if (got.cell_day !== want.cell_day)
                report($sformatf("cell %0d day %0d, want %0d",
                                 want.cell_index, got.cell_day, want.cell_day));
            if (got.cell_index !== want.cell_index)
                report($sformatf("cell index %0d, want %0d",
                                 got.cell_index, want.cell_index));
            if (got.last_cell !== want.last_cell)
                report($sformatf("cell %0d last flag %b, want %b",
                                 want.cell_index, got.last_cell, want.last_cell));
        endtask
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    cmg_pkg::t_req            i_req       = '0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    cmg_pkg::t_cell           o_cell;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [cmg_pkg::WS_W-1:0] i_cfg_data  = '0;

    grid_tracker tracker = new();
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned rx_hold = 1;

    calendar_month_grid_core #(
        .GRID_CELLS(CELLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cell     (o_cell),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("calendar_month_grid_core verification failed");
        $finish;
    end

    // wait per word, with calm stretches where nothing idles
    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // cell side: take a word, then maybe stall for a while
    always @(posedge i_clk) begin
        int unsigned gap;
        if (i_rst_n) begin
            if (rx_hold > 0) begin
                rx_hold--;
                if (rx_hold == 0) i_ready <= 1'b1;
            end else if (o_valid && i_ready) begin
                tracker.check_cell(o_cell);
                gap = draw_wait(rx_calm);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    rx_hold = gap;
                end
            end
        end
    end

    task automatic issue(input logic [YW-1:0] y, input logic [MW-1:0] m);
        cmg_pkg::t_req r;
        int unsigned   gap;
        r.req_year  = y;
        r.req_month = m;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.lay_out_month(r);
    endtask

    task automatic random_request();
        logic [YW-1:0] y;
        logic [MW-1:0] m;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        m    = MW'($urandom_range(1, 12));
        if (pick < 8) begin
            // raw field bits, clamping included
            y = YW'($urandom);
            m = MW'($urandom);
        end else if (pick < 22) begin
            case ($urandom_range(0, 5))
                0:       y = YW'(1);
                1:       y = YW'(2);
                2:       y = YW'(9998);
                3:       y = YW'(9999);
                4:       y = YW'(100 * $urandom_range(1, 99));
                default: y = YW'(4 * $urandom_range(1, 2499));
            endcase
        end else begin
            y = YW'($urandom_range(1, 9999));
        end
        issue(y, m);
    endtask

    // every grid pending has been taken
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_cells.size() != 0);
    endtask

    task automatic write_week_start(input logic [cmg_pkg::WS_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.week_start = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [cmg_pkg::WS_W-1:0] ws_plan[8];
        int                       mo;
        int                       p;
        ws_plan = '{3'd7, 3'd6, 3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edges of the year range, clamped fields and leap rules
        issue(14'd1, 4'd1);
        issue(14'd9999, 4'd12);
        issue(14'd0, 4'd0);
        issue(14'h3fff, 4'hf);
        issue(14'd10000, 4'd13);
        issue(14'd2000, 4'd2);
        issue(14'd1900, 4'd2);
        issue(14'd2024, 4'd2);
        issue(14'd2023, 4'd2);
        for (mo = 1; mo <= 12; mo++)
            issue(14'd2021, mo[MW-1:0]);

        for (p = 0; p < 8; p++) begin
            drain();
            write_week_start(ws_plan[p]);
            issue(14'd1, 4'd1);
            issue(14'd9999, 4'd12);
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("calendar_month_grid_core verification clean");
        else
            $display("calendar_month_grid_core verification failed");
        $finish;
    end

endmodule

@@ calendar_month_grid_core.f @@
rtl/cmg_pkg.sv
rtl/cmg_front.sv
rtl/cmg_queue.sv
rtl/cmg_back.sv
rtl/calendar_month_grid_core.sv
sim/tb_top.sv
